[design/trle_pkg.sv]
// Shared types and constants for the run-length coded TGA pixel decoder.
// No dependencies; used by trle_core and tga_rle_pixel_decoder.
`timescale 1ns / 1ps

package trle_pkg;

  // Default width of the image pixel counter.
  localparam int DEF_PIXEL_COUNT_BITS = 25;

  // Fixed field widths.
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 8;
  localparam int BPP_W   = 3;
  localparam int TOTAL_W = 25;
  localparam int HOLD_W  = 24;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register indexes, taken from paddr[2].
  localparam logic [0:0] REG_BPP   = 1'b0;
  localparam logic [0:0] REG_TOTAL = 1'b1;

  // Register reset values and codes.
  localparam logic [BPP_W-1:0]   BPP_NARROW  = 3'd3;
  localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 25'd1;

  // Packet header layout.
  localparam int RUN_FLAG_BIT = 7;

  typedef enum logic [1:0] {
    PH_HEADER = 2'b01,
    PH_COLOUR = 2'b10
  } phase_t;

  // One decoded pixel result.
  typedef struct packed {
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  green;
    logic [BYTE_W-1:0]  blue;
    logic [BYTE_W-1:0]  alpha;
    logic [COUNT_W-1:0] repeat_count;
    logic               image_done;
    logic               overrun;
  } pix_t;

endpackage

[design/trle_core.sv]
// Packet and pixel state of the TGA run-length decoder: one stream byte in,
// at most one pixel result out in the same cycle. Depends on trle_pkg.
`timescale 1ns / 1ps

module trle_core #(
  parameter int PIXEL_COUNT_BITS = trle_pkg::DEF_PIXEL_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic [trle_pkg::BYTE_W-1:0]    data_byte,
  input  logic [trle_pkg::BPP_W-1:0]     bytes_per_pixel,
  input  logic [trle_pkg::TOTAL_W-1:0]   pixel_total,
  input  logic                           total_wr,
  input  logic [trle_pkg::TOTAL_W-1:0]   total_wdata,
  output logic                           res_valid,
  output trle_pkg::pix_t                 res
);

  localparam int CW = PIXEL_COUNT_BITS;
  localparam int TW = (CW < trle_pkg::TOTAL_W) ? CW : trle_pkg::TOTAL_W;

  // A total of zero after masking counts as one pixel.
  function automatic logic [CW-1:0] eff_total(input logic [trle_pkg::TOTAL_W-1:0] t);
    logic [CW-1:0] v;
    v = CW'(t[TW-1:0]);
    if (v == '0) begin
      v = CW'(1);
    end
    return v;
  endfunction

  trle_pkg::phase_t               phase, phase_next;
  logic                           run_packet, run_packet_next;
  logic [trle_pkg::COUNT_W-1:0]   pixels_left, pixels_left_next;
  logic [1:0]                     byte_in_pixel, byte_in_pixel_next;
  logic [trle_pkg::HOLD_W-1:0]    colour_hold, colour_hold_next;
  logic [CW-1:0]                  pixels_done, pixels_done_next;
  logic [CW-1:0]                  remaining, remaining_next;

  logic [CW-1:0]                  total_sel;
  logic                           wide;
  logic [1:0]                     last_idx;
  logic                           clip;
  logic                           done;
  logic [trle_pkg::COUNT_W-1:0]   count;
  logic [trle_pkg::COUNT_W-1:0]   left_dec;

  // Pixels still missing in the image. It is registered from pixels_done and so
  // trails it, which is safe because two pixel results are always at least three
  // bytes apart. A total written in this cycle is taken directly from the port.
  always_comb begin
    total_sel = eff_total(total_wr ? total_wdata : pixel_total);
    remaining_next = (pixels_done < total_sel) ? (total_sel - pixels_done) : CW'(1);
  end

  always_comb begin
    phase_next         = phase;
    run_packet_next    = run_packet;
    pixels_left_next   = pixels_left;
    byte_in_pixel_next = byte_in_pixel;
    colour_hold_next   = colour_hold;
    pixels_done_next   = pixels_done;
    res_valid          = 1'b0;
    res                = '0;
    wide               = (bytes_per_pixel != trle_pkg::BPP_NARROW);
    last_idx           = wide ? 2'd3 : 2'd2;
    clip               = (CW'(pixels_left) > remaining);
    count              = 8'd1;
    left_dec           = pixels_left - 8'd1;
    done               = 1'b0;

    if (take) begin
      if (phase != trle_pkg::PH_COLOUR) begin
        run_packet_next    = data_byte[trle_pkg::RUN_FLAG_BIT];
        pixels_left_next   = {1'b0, data_byte[trle_pkg::RUN_FLAG_BIT-1:0]} + 8'd1;
        byte_in_pixel_next = 2'd0;
        phase_next         = trle_pkg::PH_COLOUR;
      end else if (byte_in_pixel < last_idx) begin
        unique case (byte_in_pixel)
          2'd0:    colour_hold_next[7:0]   = data_byte;
          2'd1:    colour_hold_next[15:8]  = data_byte;
          default: colour_hold_next[23:16] = data_byte;
        endcase
        byte_in_pixel_next = byte_in_pixel + 2'd1;
      end else begin
        // Last byte of a pixel: emit it.
        res_valid          = 1'b1;
        byte_in_pixel_next = 2'd0;
        res.blue           = colour_hold[7:0];
        res.green          = colour_hold[15:8];
        res.red            = wide ? colour_hold[23:16] : data_byte;
        res.alpha          = wide ? data_byte : 8'd0;

        if (run_packet) begin
          count            = clip ? remaining[trle_pkg::COUNT_W-1:0] : pixels_left;
          res.overrun      = clip;
          pixels_left_next = '0;
          phase_next       = trle_pkg::PH_HEADER;
        end else begin
          pixels_left_next = left_dec;
          if (left_dec == '0) begin
            phase_next = trle_pkg::PH_HEADER;
          end
        end

        done = (CW'(count) >= remaining);
        if (done) begin
          if (!run_packet && left_dec != '0) begin
            res.overrun = 1'b1;
          end
          pixels_done_next = '0;
          pixels_left_next = '0;
          phase_next       = trle_pkg::PH_HEADER;
        end else begin
          pixels_done_next = pixels_done + CW'(count);
        end
        res.repeat_count = count;
        res.image_done   = done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= trle_pkg::PH_HEADER;
      run_packet    <= 1'b0;
      pixels_left   <= '0;
      byte_in_pixel <= 2'd0;
      colour_hold   <= '0;
      pixels_done   <= '0;
      remaining     <= CW'(1);
    end else begin
      phase         <= phase_next;
      run_packet    <= run_packet_next;
      pixels_left   <= pixels_left_next;
      byte_in_pixel <= byte_in_pixel_next;
      colour_hold   <= colour_hold_next;
      pixels_done   <= pixels_done_next;
      remaining     <= remaining_next;
    end
  end

endmodule

[design/tga_rle_pixel_decoder.sv]
// Top level of the run-length coded true-color TGA pixel decoder: register
// port, decoder core and result buffer. Depends on trle_pkg and trle_core.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid, in_stall, data_byte) carries the compressed
// pixel stream, one byte per transfer: packet headers and color bytes in
// blue, green, red, alpha order. The output channel (out_valid, out_stall
// and the red, green, blue, alpha, repeat_count, image_done, overrun fields)
// carries one transfer per run packet and one per pixel of a raw packet.
// A transfer is taken at a rising edge where valid is high and stall is low.
// Throughput is one input byte per clock while in_stall is low. The byte that
// completes a pixel produces its result on the output via the result register;
// header and other color bytes produce nothing. The per-byte work is a single
// pass through the decoder core between the input and the result register.
// The result register is backed by a one-entry skid stage, so the decoder
// keeps taking bytes while a result waits. When both are full, in_stall is
// raised until the receiver takes a result; no result is lost or repeated.
// bytes_per_pixel (address 0) and pixel_total (address 4) are to be written
// through the APB-style port while the stream is idle; the block does not enforce it.
// Synchronous reset restores 32-bit pixels, a total of one pixel, and a header wait.

module tga_rle_pixel_decoder #(
  parameter int PIXEL_COUNT_BITS = trle_pkg::DEF_PIXEL_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [trle_pkg::ADDR_W-1:0]    paddr,
  input  logic [trle_pkg::DATA_W-1:0]    pwdata,
  output logic [trle_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  // Byte stream in
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [trle_pkg::BYTE_W-1:0]    data_byte,
  // Pixel results out
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [trle_pkg::BYTE_W-1:0]    red,
  output logic [trle_pkg::BYTE_W-1:0]    green,
  output logic [trle_pkg::BYTE_W-1:0]    blue,
  output logic [trle_pkg::BYTE_W-1:0]    alpha,
  output logic [trle_pkg::COUNT_W-1:0]   repeat_count,
  output logic                           image_done,
  output logic                           overrun
);

  // Configuration registers.
  logic [trle_pkg::BPP_W-1:0]   bytes_per_pixel;
  logic [trle_pkg::TOTAL_W-1:0] pixel_total;
  logic                         cfg_wr;
  logic [0:0]                   reg_idx;
  logic                         total_wr;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[trle_pkg::ADDR_W-1];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign total_wr = cfg_wr && (reg_idx == trle_pkg::REG_TOTAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= trle_pkg::BPP_RESET;
      pixel_total     <= trle_pkg::TOTAL_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        trle_pkg::REG_BPP:   bytes_per_pixel <= pwdata[trle_pkg::BPP_W-1:0];
        trle_pkg::REG_TOTAL: pixel_total     <= pwdata[trle_pkg::TOTAL_W-1:0];
        default:             bytes_per_pixel <= bytes_per_pixel;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      trle_pkg::REG_BPP:   prdata = trle_pkg::DATA_W'(bytes_per_pixel);
      trle_pkg::REG_TOTAL: prdata = trle_pkg::DATA_W'(pixel_total);
      default:             prdata = '0;
    endcase
  end

  // Decoder core.
  logic           in_take;
  logic           res_valid;
  trle_pkg::pix_t res;

  assign in_take = in_valid && !in_stall;

  trle_core #(
    .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .take            (in_take),
    .data_byte       (data_byte),
    .bytes_per_pixel (bytes_per_pixel),
    .pixel_total     (pixel_total),
    .total_wr        (total_wr),
    .total_wdata     (pwdata[trle_pkg::TOTAL_W-1:0]),
    .res_valid       (res_valid),
    .res             (res)
  );

  // Result register with a skid entry behind it. The input stalls only
  // while the skid entry holds a result, so a new byte is not refused while
  // only the result register waits on the receiver.
  trle_pkg::pix_t out_q;
  trle_pkg::pix_t skid_q;
  logic           skid_valid;
  logic           out_take;

  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_take) begin
      out_valid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_valid || out_take) begin
      if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign red          = out_q.red;
  assign green        = out_q.green;
  assign blue         = out_q.blue;
  assign alpha        = out_q.alpha;
  assign repeat_count = out_q.repeat_count;
  assign image_done   = out_q.image_done;
  assign overrun      = out_q.overrun;

endmodule
